FILE: rtl/fbfl_pkg.sv
// Shared types and constants of the fixed block free-list allocator.
package fbfl_pkg;

  localparam int IDX_W       = 8;
  localparam int CNT_W       = 9;
  localparam int BYTES_W     = 17;
  localparam int OFF_W       = 24;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 17;
  localparam int INDEX_SPACE = 256;

  localparam logic [BYTES_W-1:0] MIN_BYTES = 17'd16;
  localparam logic [BYTES_W-1:0] RESET_BYTES = 17'd64;
  localparam logic [CNT_W-1:0] RESET_BLOCKS = 9'd256;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES   = 1'd1;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic             action;
    logic [IDX_W-1:0] block_index;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] granted_index;
    logic [OFF_W-1:0] byte_offset;
    logic [CNT_W-1:0] free_blocks;
  } rsp_t;

  // One link word: successor index plus end-of-list mark.
  typedef struct packed {
    logic             tail;
    logic [IDX_W-1:0] link;
  } link_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    link_t            wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             clear;
  } mem_req_t;

  typedef struct packed {
    logic               rebuild;
    logic [CNT_W-1:0]   rebuild_pool;
    logic [CNT_W-1:0]   pool;
    logic [BYTES_W-1:0] bytes;
  } ctrl_cfg_t;

endpackage

FILE: rtl/fbfl_stream_if.sv
// Valid/ready stream interface used by the request and response channels.
interface fbfl_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/fbfl_link_mem.sv
// Link memory: successor and tail mark per block, with per-entry valid bits.
module fbfl_link_mem
  import fbfl_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic     clk,
  input  logic     rst,
  input  mem_req_t mreq,
  output link_t    rdata
);

  localparam int AW = $clog2(DEPTH);

  link_t            mem [DEPTH];
  logic [DEPTH-1:0] valid;
  link_t            rd_q;
  logic             rd_valid_q;
  logic [AW-1:0]    rd_addr_q;
  logic [AW-1:0]    prev_addr;
  link_t            init_word;

  always_ff @(posedge clk) begin
    if (mreq.we) begin
      mem[mreq.waddr[AW-1:0]] <= mreq.wdata;
    end
    if (mreq.re) begin
      rd_q      <= mem[mreq.raddr[AW-1:0]];
      rd_addr_q <= mreq.raddr[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || mreq.clear) begin
      valid <= '0;
    end else if (mreq.we) begin
      valid[mreq.waddr[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid_q <= 1'b0;
    end else if (mreq.re) begin
      rd_valid_q <= valid[mreq.raddr[AW-1:0]];
    end
  end

  // An unwritten entry reads as the initial chain: i links to i minus one.
  assign prev_addr      = rd_addr_q - AW'(1);
  assign init_word.tail = (rd_addr_q == '0);
  assign init_word.link = (rd_addr_q == '0) ? '0 : IDX_W'(prev_addr);

  assign rdata = rd_valid_q ? rd_q : init_word;

endmodule

FILE: rtl/fbfl_ctrl.sv
// Free-list controller: head, count, request sequencing and result register.
module fbfl_ctrl
  import fbfl_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst,
  fbfl_stream_if.sink   req,
  fbfl_stream_if.source rsp,
  input  ctrl_cfg_t cfg,
  output mem_req_t  mreq,
  input  link_t     rdata
);

  localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_M1  = CNT_W'(DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FETCH = 2'b10
  } state_t;

  state_t                     state, state_next;
  logic [IDX_W-1:0]           head, head_next;
  logic                       empty, empty_next;
  logic [CNT_W-1:0]           total, total_next;
  logic                       out_valid, out_valid_next;
  rsp_t                       out_data, out_next;
  logic                       accept;
  logic                       head_ok;
  logic [BYTES_W-1:0]         eff_bytes;
  logic [IDX_W+BYTES_W-1:0]   product;
  logic [CNT_W-1:0]           pool_m1;
  req_t                       item;

  assign item      = req.payload;
  assign req.ready = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;

  assign head_ok   = !empty && ({1'b0, head} < DEPTH_C);
  assign eff_bytes = (cfg.bytes < MIN_BYTES) ? MIN_BYTES : cfg.bytes;
  assign product   = head * eff_bytes;
  assign pool_m1   = cfg.rebuild_pool - CNT_W'(1);

  always_comb begin
    state_next     = state;
    head_next      = head;
    empty_next     = empty;
    total_next     = total;
    out_valid_next = out_valid && !rsp.ready;
    out_next       = out_data;
    mreq           = '0;

    if (accept) begin
      if (item.action == ACT_ALLOC) begin
        if (head_ok) begin
          mreq.re    = 1'b1;
          mreq.raddr = head;
          state_next = ST_FETCH;
        end else begin
          out_valid_next = 1'b1;
          out_next       = '{STATUS_EMPTY, '0, '0, total};
        end
      end else begin
        if ({1'b0, item.block_index} >= cfg.pool) begin
          out_valid_next = 1'b1;
          out_next       = '{STATUS_RANGE, '0, '0, total};
        end else begin
          mreq.we         = 1'b1;
          mreq.waddr      = item.block_index;
          mreq.wdata.tail = empty;
          mreq.wdata.link = head;
          head_next       = item.block_index;
          empty_next      = 1'b0;
          total_next      = (total < cfg.pool) ? total + CNT_W'(1) : total;
          out_valid_next  = 1'b1;
          out_next        = '{STATUS_OK, '0, '0, total_next};
        end
      end
    end

    if (state == ST_FETCH) begin
      head_next      = rdata.link;
      empty_next     = rdata.tail;
      total_next     = (total != '0) ? total - CNT_W'(1) : total;
      out_valid_next = 1'b1;
      out_next       = '{STATUS_OK, head, product[OFF_W-1:0], total_next};
      state_next     = ST_IDLE;
    end

    // Rewriting the pool size rebuilds the whole list.
    if (cfg.rebuild) begin
      mreq.clear = 1'b1;
      empty_next = (cfg.rebuild_pool == '0);
      head_next  = (cfg.rebuild_pool == '0) ? '0 : pool_m1[IDX_W-1:0];
      total_next = cfg.rebuild_pool;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= DEPTH_M1[IDX_W-1:0];
      empty     <= 1'b0;
      total     <= DEPTH_C;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      empty     <= empty_next;
      total     <= total_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_next;
  end

`ifndef SYNTHESIS
  a_total_le_pool: assert property (@(posedge clk) disable iff (rst)
    total <= cfg.pool)
    else $error("free count exceeds pool size");

  a_fetch_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) |-> !out_valid)
    else $error("result register busy during link fetch");

  a_head_in_pool: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ({1'b0, head} < cfg.pool))
    else $error("list head outside pool");

  a_alloc_fetch: assert property (@(posedge clk) disable iff (rst)
    (accept && item.action == ACT_ALLOC && head_ok && !cfg.rebuild)
      |=> (state == ST_FETCH))
    else $error("allocate did not start link fetch");
`endif

endmodule

FILE: rtl/fixed_block_free_list_allocator.sv
// Top level of the fixed block free-list allocator.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    action, block_index
//   rsp      out  valid/ready    status, granted_index, byte_offset, free_blocks
//   cfg      in   cfg_we only    cfg_index, cfg_wdata
//
// A free puts its result in the output register in the cycle after it is
// taken. An allocate reads the head entry through the registered link memory
// read in the fetch state, and its result is registered after that. Reset
// and a write of blocks_in_use rebuild the list at once: the link memory
// valid bits all clear together and unwritten entries read as the initial
// chain. A stalled result holds in the output register; a new request is
// taken while idle as soon as that register is being emptied.
module fixed_block_free_list_allocator
  import fbfl_pkg::*;
#(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  fbfl_stream_if.sink           req,
  fbfl_stream_if.source         rsp
);

  // Indices are 8 bits wide, so no more than 256 blocks are ever addressed.
  localparam int DEPTH = (MAX_BLOCKS < INDEX_SPACE) ? MAX_BLOCKS : INDEX_SPACE;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [CNT_W-1:0]   blocks_in_use;
  logic [BYTES_W-1:0] block_bytes;
  logic [CNT_W-1:0]   new_blocks;
  ctrl_cfg_t          cfg;
  mem_req_t           mreq;
  link_t              rdata;

  // Hold the configuration registers; only the low bits of a beat count.
  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= RESET_BLOCKS;
      block_bytes   <= RESET_BYTES;
    end else if (cfg_we) begin
      if (cfg_index == REG_BLOCKS_IN_USE) begin
        blocks_in_use <= cfg_wdata[CNT_W-1:0];
      end else if (cfg_index == REG_BLOCK_BYTES) begin
        block_bytes <= cfg_wdata[BYTES_W-1:0];
      end
    end
  end

  // Limit the pool to the memory depth; the new size is used on the write
  // cycle itself so the list is ready on the very next cycle.
  assign new_blocks       = cfg_wdata[CNT_W-1:0];
  assign cfg.pool         = (blocks_in_use > DEPTH_C) ? DEPTH_C : blocks_in_use;
  assign cfg.rebuild_pool = (new_blocks > DEPTH_C) ? DEPTH_C : new_blocks;
  assign cfg.rebuild      = cfg_we && (cfg_index == REG_BLOCKS_IN_USE);
  assign cfg.bytes        = block_bytes;

  fbfl_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rsp   (rsp),
    .cfg   (cfg),
    .mreq  (mreq),
    .rdata (rdata)
  );

  fbfl_link_mem #(
    .DEPTH (DEPTH)
  ) u_link_mem (
    .clk   (clk),
    .rst   (rst),
    .mreq  (mreq),
    .rdata (rdata)
  );

endmodule
